### src/ffwa_pkg.sv
package ffwa_pkg;

	// fixed field widths
	localparam int unsigned NODE_W  = 4;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned WORD_W  = 64;

	// first-fit unit: one chunk of lanes per cycle
	localparam int unsigned LANES   = 8;
	localparam int unsigned CHUNKS  = WORD_W / LANES;
	localparam int unsigned CHUNK_W = $clog2(CHUNKS);

	typedef enum logic [1:0] {
		ST_ALLOC = 2'd0,
		ST_BLOCK = 2'd1,
		ST_REL   = 2'd2,
		ST_LONG  = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic clr_en;
		logic capture;
		logic accum;
		logic route_init;
		logic fit_step;
		logic wb_rd;
		logic wb_wr;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic last_link;
		logic overflow;
		logic release_req;
		logic fit_last;
		logic blocked;
		logic wb_last;
	} sts_t;

endpackage

### src/first_fit_core_wavelength_allocator_core.sv
// link item that is not the last: accepted, then busy for one cycle; no new item is taken while busy
// last link, allocate: done strobes after the accumulate and decide states, the first-fit unit
//   stepping through every chunk of lanes, a check, and one read-modify-write of the occupancy
//   memory per stored hop; blocked ends at the check, release skips the fit, too long ends at decide
// after reset the occupancy memory is cleared, one entry a cycle, all NODES*NODES entries, busy high
// results are strobed on done for one cycle; the receiver cannot stall
module first_fit_core_wavelength_allocator_core #(
	parameter int unsigned NODES       = 16,
	parameter int unsigned CORES       = 4,
	parameter int unsigned WAVELENGTHS = 16,
	parameter int unsigned MAX_HOPS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input transaction: one route link
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [ffwa_pkg::NODE_W-1:0]   from_node,
	input  logic [ffwa_pkg::NODE_W-1:0]   to_node,
	input  logic                          last_link,
	input  logic [ffwa_pkg::COUNT_W-1:0]  slot_count,
	input  logic [ffwa_pkg::WORD_W-1:0]   release_mask,
	// result transaction: one per route, on its last link
	output logic                          done,
	output logic [1:0]                    status,
	output logic [ffwa_pkg::WORD_W-1:0]   slot_mask
);

	// command and status bundles between sequencer and datapath
	ffwa_pkg::cmd_t    cmd;
	ffwa_pkg::sts_t    sts;
	ffwa_pkg::status_t status_w;

	// sequencer: memory clear, link accumulation, first fit, per-hop write-back
	ffwa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	// datapath: occupancy memory, route store, union of occupancy, first-fit lanes
	ffwa_dp #(
		.NODES       (NODES),
		.CORES       (CORES),
		.WAVELENGTHS (WAVELENGTHS),
		.MAX_HOPS    (MAX_HOPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.from_node    (from_node),
		.to_node      (to_node),
		.last_link    (last_link),
		.slot_count   (slot_count),
		.release_mask (release_mask),
		.status       (status_w),
		.slot_mask    (slot_mask)
	);

	// result code is held stable by the datapath while done is high
	assign status = status_w;

endmodule

### src/ffwa_ctrl.sv
module ffwa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	input  ffwa_pkg::sts_t  sts,
	output ffwa_pkg::cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ACCUM,
		S_DECIDE,
		S_FIT,
		S_CHECK,
		S_WB_RD,
		S_WB_WR,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_ACCUM;
			end
			S_ACCUM: begin
				state_d = sts.last_link ? S_DECIDE : S_IDLE;
			end
			S_DECIDE: begin
				priority if (sts.overflow) state_d = S_RESULT;
				else if (sts.release_req) state_d = S_WB_RD;
				else state_d = S_FIT;
			end
			S_FIT: begin
				if (sts.fit_last) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = sts.blocked ? S_RESULT : S_WB_RD;
			end
			S_WB_RD: begin
				state_d = S_WB_WR;
			end
			S_WB_WR: begin
				state_d = sts.wb_last ? S_RESULT : S_WB_RD;
			end
			S_RESULT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.clr_en     = (state_q == S_CLEAR);
		cmd.capture    = (state_q == S_IDLE) && start;
		cmd.accum      = (state_q == S_ACCUM);
		cmd.route_init = (state_q == S_DECIDE);
		cmd.fit_step   = (state_q == S_FIT);
		cmd.wb_rd      = (state_q == S_WB_RD);
		cmd.wb_wr      = (state_q == S_WB_WR);
		cmd.finish     = (state_q == S_RESULT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_d == S_RESULT);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && state_q == S_ACCUM))
		else $error("accepted transaction not taken into accumulation");

endmodule

### src/ffwa_dp.sv
module ffwa_dp #(
	parameter int unsigned NODES       = 16,
	parameter int unsigned CORES       = 4,
	parameter int unsigned WAVELENGTHS = 16,
	parameter int unsigned MAX_HOPS    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ffwa_pkg::cmd_t                     cmd,
	output ffwa_pkg::sts_t                     sts,
	input  logic                               req_type,
	input  logic [ffwa_pkg::NODE_W-1:0]        from_node,
	input  logic [ffwa_pkg::NODE_W-1:0]        to_node,
	input  logic                               last_link,
	input  logic [ffwa_pkg::COUNT_W-1:0]       slot_count,
	input  logic [ffwa_pkg::WORD_W-1:0]        release_mask,
	output ffwa_pkg::status_t                  status,
	output logic [ffwa_pkg::WORD_W-1:0]        slot_mask
);

	localparam int unsigned NW    = $clog2(NODES);
	localparam int unsigned DEPTH = NODES * NODES;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned HW    = $clog2(MAX_HOPS + 1);
	localparam int unsigned HIW   = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
	localparam int unsigned SLOTS = CORES * WAVELENGTHS;
	localparam int unsigned WW    = ffwa_pkg::WORD_W;
	localparam int unsigned CW    = ffwa_pkg::COUNT_W;
	localparam int unsigned LN    = ffwa_pkg::LANES;
	localparam int unsigned CHW   = ffwa_pkg::CHUNK_W;
	localparam int unsigned NIN   = 1 << ffwa_pkg::NODE_W;
	localparam logic [WW-1:0] VALID_MASK =
		(SLOTS >= WW) ? {WW{1'b1}} : ((64'd1 << SLOTS) - 64'd1);

	// node number modulo NODES
	logic [NW-1:0] node_mod [NIN];
	for (genvar g = 0; g < NIN; g++) begin : g_mod
		localparam logic [NW-1:0] MOD_VAL = NW'(g % NODES);
		assign node_mod[g] = MOD_VAL;
	end

	logic [AW-1:0] in_addr;
	assign in_addr = AW'(NODES) * AW'(node_mod[from_node]) + AW'(node_mod[to_node]);

	// captured fields
	logic          req_q;
	logic          last_q;
	logic [CW-1:0] want_q;
	logic [WW-1:0] rmask_q;
	logic [AW-1:0] addr_q;

	// route state
	logic [WW-1:0]  union_q;
	logic [HW-1:0]  hop_q;
	logic           over_q;
	logic [AW-1:0]  route_q [MAX_HOPS];
	logic [HIW-1:0] wb_q;
	logic           hop_room;

	// first fit
	logic [WW-1:0]  grant_q;
	logic [CW-1:0]  taken_q;
	logic [CHW-1:0] chunk_q;
	logic [WW-1:0]  free_w;
	logic [LN-1:0]  free_chunk;
	logic [LN-1:0]  fit_bits;
	logic [CW-1:0]  fit_taken;

	// occupancy memory
	logic [WW-1:0] occ_mem [DEPTH];
	logic [WW-1:0] rdata_q;
	logic [AW-1:0] clr_q;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_wa;
	logic [AW-1:0] mem_ra;
	logic [WW-1:0] mem_wd;
	logic [AW-1:0] wb_addr;

	assign hop_room = (hop_q < HW'(MAX_HOPS));
	assign wb_addr  = route_q[wb_q];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			last_q  <= last_link;
			want_q  <= slot_count;
			rmask_q <= release_mask;
			addr_q  <= in_addr;
		end
		if (cmd.accum && hop_room) begin
			route_q[hop_q[HIW-1:0]] <= addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			union_q <= '0;
			hop_q   <= '0;
			over_q  <= 1'b0;
			clr_q   <= '0;
		end else begin
			if (cmd.clr_en) clr_q <= clr_q + AW'(1);
			priority if (cmd.finish) begin
				union_q <= '0;
				hop_q   <= '0;
				over_q  <= 1'b0;
			end else if (cmd.accum) begin
				if (hop_room) begin
					hop_q   <= hop_q + HW'(1);
					union_q <= union_q | rdata_q;
				end else begin
					over_q <= 1'b1;
				end
			end
		end
	end

	// eight lanes of first fit per cycle
	assign free_w     = ~union_q & VALID_MASK;
	assign free_chunk = free_w[{chunk_q, 3'b000} +: LN];

	always_comb begin
		fit_taken = taken_q;
		fit_bits  = '0;
		for (int j = 0; j < LN; j++) begin
			if (free_chunk[j] && (fit_taken < want_q)) begin
				fit_bits[j] = 1'b1;
				fit_taken   = fit_taken + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grant_q <= '0;
			taken_q <= '0;
			chunk_q <= '0;
			wb_q    <= '0;
		end else begin
			priority if (cmd.route_init) begin
				grant_q <= '0;
				taken_q <= '0;
				chunk_q <= '0;
				wb_q    <= '0;
			end else if (cmd.fit_step) begin
				grant_q[{chunk_q, 3'b000} +: LN] <= fit_bits;
				taken_q <= fit_taken;
				chunk_q <= chunk_q + CHW'(1);
			end else if (cmd.wb_wr) begin
				wb_q <= wb_q + HIW'(1);
			end
		end
	end

	assign mem_we = cmd.clr_en | cmd.wb_wr;
	assign mem_re = cmd.capture | cmd.wb_rd;
	assign mem_wa = cmd.clr_en ? clr_q : wb_addr;
	assign mem_ra = cmd.capture ? in_addr : wb_addr;

	always_comb begin
		priority if (cmd.clr_en) mem_wd = '0;
		else if (req_q) mem_wd = rdata_q & ~(rmask_q & VALID_MASK);
		else mem_wd = rdata_q | grant_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) occ_mem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= occ_mem[mem_ra];
	end

	always_comb begin
		sts             = '0;
		sts.clr_last    = (clr_q == AW'(DEPTH - 1));
		sts.last_link   = last_q;
		sts.overflow    = over_q;
		sts.release_req = req_q;
		sts.fit_last    = (chunk_q == CHW'(ffwa_pkg::CHUNKS - 1));
		sts.blocked     = (want_q == '0) || (taken_q < want_q);
		sts.wb_last     = ((HW'(wb_q) + HW'(1)) == hop_q);
	end

	always_comb begin
		priority if (over_q) status = ffwa_pkg::ST_LONG;
		else if (req_q) status = ffwa_pkg::ST_REL;
		else if (sts.blocked) status = ffwa_pkg::ST_BLOCK;
		else status = ffwa_pkg::ST_ALLOC;
	end

	assign slot_mask = (status == ffwa_pkg::ST_ALLOC) ? grant_q : '0;

	a_hop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hop_q <= HW'(MAX_HOPS))
		else $error("hop count beyond route storage");

	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && status == ffwa_pkg::ST_ALLOC) |->
		($countones(grant_q) == int'(want_q) && (grant_q & ~VALID_MASK) == '0))
		else $error("granted mask does not match requested slot count");

endmodule

### test/first_fit_core_wavelength_allocator_core_tb.sv
`timescale 1ns / 100ps

module first_fit_core_wavelength_allocator_core_tb;

	// block configuration, passed to the instance and mirrored by the predictor
	localparam int unsigned NODES       = 16;
	localparam int unsigned CORES       = 4;
	localparam int unsigned WAVELENGTHS = 16;
	localparam int unsigned MAX_HOPS    = 16;

	// only the lowest cores*wavelengths bits are real slots
	localparam logic [ffwa_pkg::WORD_W-1:0] VALID_SLOTS =
		(CORES * WAVELENGTHS >= ffwa_pkg::WORD_W) ? '1 :
		((64'd1 << (CORES * WAVELENGTHS)) - 64'd1);

	// random link transactions after the directed ones
	localparam int RANDOM_LINKS = 800;
	// quiet cycles tolerated: covers the clearing pass, the slowest route and sender gaps
	localparam int QUIET_LIMIT  = 2000;
	// drain time after the last outcome, above the slowest route latency
	localparam int DRAIN_CYCLES = 60;

	typedef logic [ffwa_pkg::NODE_W-1:0]  node_t;
	typedef logic [ffwa_pkg::COUNT_W-1:0] count_t;

	// one route link as offered to the block
	typedef struct {
		logic                        req_type;
		node_t                       from_node;
		node_t                       to_node;
		logic                        last_link;
		count_t                      slot_count;
		logic [ffwa_pkg::WORD_W-1:0] release_mask;
	} link_t;

	// outcome of one completed route
	typedef struct {
		ffwa_pkg::status_t           status;
		logic [ffwa_pkg::WORD_W-1:0] mask;
	} outcome_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic                          req_type = 1'b0;
	logic [ffwa_pkg::NODE_W-1:0]   from_node = '0;
	logic [ffwa_pkg::NODE_W-1:0]   to_node = '0;
	logic                          last_link = 1'b0;
	logic [ffwa_pkg::COUNT_W-1:0]  slot_count = '0;
	logic [ffwa_pkg::WORD_W-1:0]   release_mask = '0;
	logic                          done;
	logic [1:0]                    status;
	logic [ffwa_pkg::WORD_W-1:0]   slot_mask;

	// links waiting to be offered, and route outcomes waiting to come back
	link_t    pending_links[$];
	outcome_t awaited_outcomes[$];
	link_t    on_wire;

	// predictor state: occupancy per directed link and the route being built
	logic [ffwa_pkg::WORD_W-1:0] link_occupancy[NODES*NODES];
	logic [7:0]                  route_pairs[MAX_HOPS];
	logic [ffwa_pkg::WORD_W-1:0] route_used;
	int                          route_len;
	logic                        route_overflow;

	// sender pacing
	int burst_left;
	int gap_left;

	// bookkeeping
	int links_sent;
	int outcomes_seen;
	int by_status[4];
	int fail_count;
	int quiet_cycles;

	first_fit_core_wavelength_allocator_core #(
		.NODES      (NODES),
		.CORES      (CORES),
		.WAVELENGTHS(WAVELENGTHS),
		.MAX_HOPS   (MAX_HOPS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.from_node   (from_node),
		.to_node     (to_node),
		.last_link   (last_link),
		.slot_count  (slot_count),
		.release_mask(release_mask),
		.done        (done),
		.status      (status),
		.slot_mask   (slot_mask)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// occupancy word index of a stored from/to pair, nodes taken modulo NODES
	function automatic int link_slot(input logic [7:0] pair);
		return (pair[7:4] % NODES) * NODES + (pair[3:0] % NODES);
	endfunction

	// predictor: folds one accepted link into the route, settles the route on its last link
	task automatic take_link(input link_t lk);
		logic [ffwa_pkg::WORD_W-1:0] free_bits;
		logic [ffwa_pkg::WORD_W-1:0] grant;
		int                          got;
		outcome_t                    res;
		if (route_len < MAX_HOPS) begin
			route_pairs[route_len] = {lk.from_node, lk.to_node};
			route_used |= link_occupancy[link_slot({lk.from_node, lk.to_node})];
			route_len++;
		end else begin
			// links beyond the hop limit are dropped but remembered
			route_overflow = 1'b1;
		end
		if (!lk.last_link)
			return;
		grant = '0;
		if (route_overflow) begin
			res.status = ffwa_pkg::ST_LONG;
		end else if (lk.req_type) begin
			// release: clear the mask on every hop, phantom slots ignored
			for (int h = 0; h < route_len; h++)
				link_occupancy[link_slot(route_pairs[h])] &= ~(lk.release_mask & VALID_SLOTS);
			res.status = ffwa_pkg::ST_REL;
		end else begin
			// first fit over slots free on every hop, lowest bit first
			free_bits = ~route_used & VALID_SLOTS;
			got = 0;
			for (int b = 0; b < ffwa_pkg::WORD_W && got < lk.slot_count; b++) begin
				if (free_bits[b]) begin
					grant[b] = 1'b1;
					got++;
				end
			end
			if (lk.slot_count == 0 || got < lk.slot_count) begin
				grant = '0;
				res.status = ffwa_pkg::ST_BLOCK;
			end else begin
				for (int h = 0; h < route_len; h++)
					link_occupancy[link_slot(route_pairs[h])] |= grant;
				res.status = ffwa_pkg::ST_ALLOC;
			end
		end
		res.mask = grant;
		awaited_outcomes.insert(awaited_outcomes.size(), res);
		route_len = 0;
		route_used = '0;
		route_overflow = 1'b0;
	endtask

	function automatic void add_link(input logic rel, input int f, input int t, input logic last,
			input int cnt, input logic [ffwa_pkg::WORD_W-1:0] mask);
		link_t lk;
		lk.req_type = rel;
		lk.from_node = node_t'(f);
		lk.to_node = node_t'(t);
		lk.last_link = last;
		lk.slot_count = count_t'(cnt);
		lk.release_mask = mask;
		pending_links.insert(pending_links.size(), lk);
	endfunction

	// route of random links; only the last link's type, count and mask take effect
	task automatic add_route(input int hops, input logic rel, input logic narrow, input int cnt,
			input logic [ffwa_pkg::WORD_W-1:0] mask);
		link_t lk;
		for (int h = 0; h < hops; h++) begin
			// narrow routes share few links so that slots run out and collide
			lk.from_node = narrow ? node_t'($urandom_range(0, 3)) : node_t'($urandom_range(0, 15));
			lk.to_node = narrow ? node_t'($urandom_range(0, 3)) : node_t'($urandom_range(0, 15));
			lk.last_link = (h == hops - 1);
			if (lk.last_link) begin
				lk.req_type = rel;
				lk.slot_count = rel ? count_t'($urandom_range(0, 127)) : count_t'(cnt);
				lk.release_mask = rel ? mask : {$urandom, $urandom};
			end else begin
				// don't-care fields on inner links, type mixed freely
				lk.req_type = 1'($urandom_range(0, 1));
				lk.slot_count = count_t'($urandom_range(0, 127));
				lk.release_mask = {$urandom, $urandom};
			end
			pending_links.insert(pending_links.size(), lk);
		end
	endtask

	// driver: offers queued links in bursts, predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		logic accepted;
		logic offer;
		if (!arst_n) begin
			start <= 1'b0;
			req_type <= 1'b0;
			from_node <= '0;
			to_node <= '0;
			last_link <= 1'b0;
			slot_count <= '0;
			release_mask <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			accepted = start && !busy;
			// a link still waiting on busy stays on the ports
			offer = start && !accepted;
			if (accepted) begin
				take_link(on_wire);
				links_sent++;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_links.size() > 0) begin
					on_wire = pending_links.pop_front();
					req_type <= on_wire.req_type;
					from_node <= on_wire.from_node;
					to_node <= on_wire.to_node;
					last_link <= on_wire.last_link;
					slot_count <= on_wire.slot_count;
					release_mask <= on_wire.release_mask;
					offer = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// a third of the bursts run straight into the next one
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			start <= offer;
		end
	end

	// monitor: each done strobe against the oldest awaited outcome, plus the watchdog
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				outcomes_seen++;
				by_status[status]++;
				if (awaited_outcomes.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected outcome: status %0d mask %h", status, slot_mask);
				end else begin
					want = awaited_outcomes.pop_front();
					if (status !== want.status || slot_mask !== want.mask) begin
						fail_count++;
						if (fail_count <= 10)
							$display("outcome %0d: status %0d (want %0d), mask %h (want %h)",
								outcomes_seen, status, want.status, slot_mask, want.mask);
					end
				end
			end
			// quiet means neither a link taken nor an outcome strobed
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int target;
		int r;
		int hops;
		int cnt;
		logic rel;
		logic [ffwa_pkg::WORD_W-1:0] mask;

		for (int i = 0; i < NODES * NODES; i++)
			link_occupancy[i] = '0;
		route_len = 0;
		route_used = '0;
		route_overflow = 1'b0;
		links_sent = 0;
		outcomes_seen = 0;
		fail_count = 0;
		quiet_cycles = 0;
		for (int i = 0; i < 4; i++)
			by_status[i] = 0;

		// directed: zero request, single slot, whole word, then a full link
		add_link(1'b0, 0, 0, 1'b1, 0, '0);
		add_link(1'b0, 0, 0, 1'b1, 1, '1);
		add_link(1'b0, 15, 15, 1'b1, 64, '0);
		add_link(1'b0, 15, 15, 1'b1, 1, '0);
		// more than the word holds is blocked
		add_link(1'b0, 3, 5, 1'b1, 127, '0);
		// three hops, inner links typed as release but the last one decides
		add_link(1'b1, 0, 0, 1'b0, 127, '1);
		add_link(1'b1, 0, 1, 1'b0, 0, '1);
		add_link(1'b0, 1, 2, 1'b1, 5, '0);
		// release everything, then partial releases, then already free slots
		add_link(1'b1, 15, 15, 1'b1, 0, '1);
		add_link(1'b1, 0, 0, 1'b1, 64, 64'h0000_0000_0000_0001);
		add_link(1'b0, 0, 1, 1'b0, 3, '0);
		add_link(1'b1, 1, 2, 1'b1, 1, 64'hffff_ffff_ffff_ffc1);
		add_link(1'b1, 7, 9, 1'b1, 0, 64'haaaa_aaaa_aaaa_aaaa);
		// one hop past the limit: route too long, nothing freed
		add_route(MAX_HOPS + 1, 1'b1, 1'b0, 0, '1);

		// random routes, mostly short and on a few shared links
		target = pending_links.size() + RANDOM_LINKS;
		while (pending_links.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				hops = $urandom_range(1, 3);
			else if (r < 85)
				hops = $urandom_range(4, MAX_HOPS - 1);
			else if (r < 93)
				hops = MAX_HOPS;
			else
				hops = $urandom_range(MAX_HOPS + 1, MAX_HOPS + 3);
			rel = ($urandom_range(0, 99) < 40);
			r = $urandom_range(0, 99);
			if (r < 5)
				cnt = 0;
			else if (r < 10)
				cnt = 64;
			else if (r < 15)
				cnt = $urandom_range(65, 127);
			else if (r < 25)
				cnt = $urandom_range(13, 63);
			else
				cnt = $urandom_range(1, 12);
			r = $urandom_range(0, 99);
			if (r < 40)
				mask = '1;
			else if (r < 70)
				mask = {$urandom, $urandom};
			else
				mask = 64'hff << (8 * $urandom_range(0, 7));
			add_route(hops, rel, ($urandom_range(0, 99) < 80), cnt, mask);
		end

		// reset held first; the block then clears its occupancy store with busy high
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// every link offered and taken, every route outcome back
		while (pending_links.size() != 0 || start || awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		// outcomes still owed after the drain never arrived
		if (awaited_outcomes.size() != 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0d route outcomes never strobed", awaited_outcomes.size());
		end

		$display("covered %0d link transactions and %0d route outcomes", links_sent,
			outcomes_seen);
		$display("allocated %0d, blocked %0d, released %0d, route too long %0d, failures %0d",
			by_status[ffwa_pkg::ST_ALLOC], by_status[ffwa_pkg::ST_BLOCK],
			by_status[ffwa_pkg::ST_REL], by_status[ffwa_pkg::ST_LONG], fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
